/* design/dcbd_pkg.sv */
// Types and constants shared by the dual-CPU bus decoder modules.
package dcbd_pkg;

    // Shared RAM geometry
    localparam int RAM_DEPTH = 9344;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // Access kinds
    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // CPU select
    localparam logic CPU_MAIN  = 1'b0;
    localparam logic CPU_AUDIO = 1'b1;

    // ROM regions
    localparam logic [2:0] REG_NONE  = 3'd0;
    localparam logic [2:0] REG_MAIN  = 3'd1;
    localparam logic [2:0] REG_BANK0 = 3'd2;
    localparam logic [2:0] REG_BANK1 = 3'd3;
    localparam logic [2:0] REG_BANK2 = 3'd4;
    localparam logic [2:0] REG_AUDIO = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_DIP_A = 2'd0;
    localparam logic [1:0] CFG_DIP_B = 2'd1;

    // Main CPU map
    localparam logic [15:0] ADDR_BANK_LIMIT = 16'hb000;
    localparam logic [15:0] ADDR_IN0        = 16'hc000;
    localparam logic [15:0] ADDR_IN1        = 16'hc001;
    localparam logic [15:0] ADDR_DIP_A      = 16'hc003;
    localparam logic [15:0] ADDR_DIP_B      = 16'hc004;
    localparam logic [15:0] ADDR_LATCH      = 16'hc800;
    localparam logic [15:0] ADDR_SCROLL_LO  = 16'hc802;
    localparam logic [15:0] ADDR_SCROLL_HI  = 16'hc803;
    localparam logic [15:0] ADDR_SUB_RESET  = 16'hc804;
    localparam logic [15:0] ADDR_PALETTE    = 16'hc805;
    localparam logic [15:0] ADDR_BANK_SEL   = 16'hc806;
    // Audio CPU map
    localparam logic [15:0] ADDR_SND_LATCH  = 16'h6000;

    // Shared RAM bases
    localparam logic [RAM_AW-1:0] BASE_WORK   = RAM_AW'(16'h0000);
    localparam logic [RAM_AW-1:0] BASE_FG     = RAM_AW'(16'h1000);
    localparam logic [RAM_AW-1:0] BASE_AUDIO  = RAM_AW'(16'h1800);
    localparam logic [RAM_AW-1:0] BASE_BG     = RAM_AW'(16'h2000);
    localparam logic [RAM_AW-1:0] BASE_SPRITE = RAM_AW'(16'h2400);

    typedef struct packed {
        logic [1:0]  kind;
        logic        cpu_sel;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [6:0]  buttons;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  rom_region;
        logic [15:0] rom_offset;
        logic [15:0] scroll_out;
        logic [7:0]  palette_out;
        logic        cpu_b_reset;
        logic        snd_write;
        logic [4:0]  snd_index;
        logic [7:0]  snd_value;
    } t_out_word;

    // Decoder result: RAM access, immediate read fields and register updates
    typedef struct packed {
        logic              ram_rd;
        logic              ram_wr;
        logic [RAM_AW-1:0] ram_addr;
        logic [7:0]        read_data;
        logic [2:0]        rom_region;
        logic [15:0]       rom_offset;
        logic              snd_write;
        logic [4:0]        snd_index;
        logic [7:0]        snd_value;
        logic              wr_latch;
        logic              wr_scroll_lo;
        logic              wr_scroll_hi;
        logic              wr_sub_reset;
        logic              wr_palette;
        logic              wr_bank;
        logic              wr_chip_addr;
        logic              chip;
        logic              coin_upd;
    } t_dec;

endpackage

/* design/dcbd_ram.sv */
// Generic single-port synchronous RAM with registered read.
module dcbd_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* design/dcbd_decode.sv */
// Address decode of one bus word into RAM access, read value, ROM report and register updates.
module dcbd_decode (
    input  dcbd_pkg::t_in_word i_word,
    input  logic [7:0]         i_bank_select,
    input  logic               i_last_coin,
    input  logic [7:0]         i_dip_a,
    input  logic [7:0]         i_dip_b,
    input  logic [7:0]         i_sound_latch,
    input  logic [3:0]         i_chip_addr0,
    input  logic [3:0]         i_chip_addr1,
    output dcbd_pkg::t_dec     o_dec
);
    import dcbd_pkg::*;

    logic              main_ram_hit;
    logic [RAM_AW-1:0] main_ram_idx;
    logic              audio_ram_hit;
    logic [RAM_AW-1:0] audio_ram_idx;
    logic [15:0]       a;
    logic              coin;
    logic [3:0]        sel_chip_addr;

    assign a    = i_word.address;
    assign coin = i_word.buttons[0];
    assign sel_chip_addr = a[14] ? i_chip_addr1 : i_chip_addr0;

    always_comb begin
        main_ram_hit = 1'b1;
        main_ram_idx = '0;
        if (a[15:12] == 4'he) begin
            main_ram_idx = BASE_WORK + RAM_AW'(a[11:0]);
        end else if (a[15:7] == 9'h198) begin
            main_ram_idx = BASE_SPRITE + RAM_AW'(a[6:0]);
        end else if (a[15:11] == 5'h1a) begin
            main_ram_idx = BASE_FG + RAM_AW'(a[10:0]);
        end else if (a[15:10] == 6'h36) begin
            main_ram_idx = BASE_BG + RAM_AW'(a[9:0]);
        end else begin
            main_ram_hit = 1'b0;
        end
    end

    assign audio_ram_hit = (a[15:11] == 5'h08);
    assign audio_ram_idx = BASE_AUDIO + RAM_AW'(a[10:0]);

    always_comb begin
        o_dec = '0;
        o_dec.read_data = 8'hff;
        o_dec.chip      = a[14];
        case (i_word.kind)
            KIND_FETCH: begin
                o_dec.rom_region = (i_word.cpu_sel == CPU_AUDIO) ? REG_AUDIO : REG_MAIN;
                o_dec.rom_offset = a;
            end
            KIND_READ: begin
                if (i_word.cpu_sel == CPU_MAIN) begin
                    if (!a[15]) begin
                        o_dec.rom_region = REG_MAIN;
                        o_dec.rom_offset = a;
                    end else if (!a[14]) begin
                        if (i_bank_select == 8'd0) begin
                            o_dec.rom_region = REG_BANK0;
                            o_dec.rom_offset = {2'b00, a[13:0]};
                        end else if (i_bank_select == 8'd1 && a < ADDR_BANK_LIMIT) begin
                            o_dec.rom_region = REG_BANK1;
                            o_dec.rom_offset = {2'b00, a[13:0]};
                        end else if (i_bank_select == 8'd2) begin
                            o_dec.rom_region = REG_BANK2;
                            o_dec.rom_offset = {2'b00, a[13:0]};
                        end
                    end else if (main_ram_hit) begin
                        o_dec.ram_rd   = 1'b1;
                        o_dec.ram_addr = main_ram_idx;
                    end else if (a == ADDR_IN0) begin
                        // coin reads active on its rising edge only
                        o_dec.read_data = {~(coin & ~i_last_coin), 6'h3f, ~i_word.buttons[1]};
                        o_dec.coin_upd  = 1'b1;
                    end else if (a == ADDR_IN1) begin
                        o_dec.read_data = {2'b11, ~i_word.buttons[1], ~i_word.buttons[6:2]};
                    end else if (a == ADDR_DIP_A) begin
                        o_dec.read_data = ~i_dip_a;
                    end else if (a == ADDR_DIP_B) begin
                        o_dec.read_data = ~i_dip_b;
                    end
                end else begin
                    if (a[15:14] == 2'b00) begin
                        o_dec.rom_region = REG_AUDIO;
                        o_dec.rom_offset = a;
                    end else if (audio_ram_hit) begin
                        o_dec.ram_rd   = 1'b1;
                        o_dec.ram_addr = audio_ram_idx;
                    end else if (a == ADDR_SND_LATCH) begin
                        o_dec.read_data = i_sound_latch;
                    end
                end
            end
            KIND_WRITE: begin
                if (i_word.cpu_sel == CPU_MAIN) begin
                    if (main_ram_hit) begin
                        o_dec.ram_wr   = 1'b1;
                        o_dec.ram_addr = main_ram_idx;
                    end else begin
                        o_dec.wr_latch     = (a == ADDR_LATCH);
                        o_dec.wr_scroll_lo = (a == ADDR_SCROLL_LO);
                        o_dec.wr_scroll_hi = (a == ADDR_SCROLL_HI);
                        o_dec.wr_sub_reset = (a == ADDR_SUB_RESET);
                        o_dec.wr_palette   = (a == ADDR_PALETTE);
                        o_dec.wr_bank      = (a == ADDR_BANK_SEL);
                    end
                end else begin
                    if (audio_ram_hit) begin
                        o_dec.ram_wr   = 1'b1;
                        o_dec.ram_addr = audio_ram_idx;
                    end else if (a[15]) begin
                        // odd address: data port, even: address latch
                        if (a[0]) begin
                            o_dec.snd_write = 1'b1;
                            o_dec.snd_index = {a[14], sel_chip_addr};
                            o_dec.snd_value = i_word.write_data;
                        end else begin
                            o_dec.wr_chip_addr = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end
endmodule

/* design/dual_cpu_bus_decoder.sv */
// Top level of the dual-CPU bus decoder: control registers, shared RAM and output pipeline.
//
// Takes one bus word per clock while o_in_stall is low and returns one result word per
// input word, in order. An accepted word decodes in the cycle it is taken: control registers
// update and a shared RAM read or write is issued at that edge. The RAM read data is
// registered by the RAM alongside the second stage, and the result then moves into an
// output register, which drives o_out_valid. The single RAM port carries one access per
// cycle, which sets the sustained rate of one word per clock when the output is not
// stalled; each word makes at most one access, so consecutive words never contend for it.
// o_in_stall rises only while the second stage holds a word that the stalled output
// register cannot take. The RAM needs no clearing after reset; DIP banks reset to zero and
// are written through the config port.
module dual_cpu_bus_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dcbd_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dcbd_pkg::t_out_word o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_wdata
);
    import dcbd_pkg::*;

    logic [7:0]  r_bank, r_latch, r_pal, r_dip_a, r_dip_b;
    logic [15:0] r_scroll;
    logic        r_sub_rst, r_last_coin;
    logic [3:0]  r_chip_addr0, r_chip_addr1;

    logic [15:0] n_scroll;
    logic [7:0]  n_pal;
    logic        n_sub_rst;

    logic        r_s1_valid, r_s1_use_ram;
    t_out_word   r_s1_res;
    logic        r_out_valid;
    t_out_word   r_out;

    t_dec        dec;
    logic        in_accept, out_ready, s1_adv;
    logic [7:0]  ram_rdata;
    t_out_word   s1_word;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_ready;
    assign o_in_stall = r_s1_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    dcbd_decode u_decode (
        .i_word        (i_in_data),
        .i_bank_select (r_bank),
        .i_last_coin   (r_last_coin),
        .i_dip_a       (r_dip_a),
        .i_dip_b       (r_dip_b),
        .i_sound_latch (r_latch),
        .i_chip_addr0  (r_chip_addr0),
        .i_chip_addr1  (r_chip_addr1),
        .o_dec         (dec)
    );

    dcbd_ram #(
        .Width (8),
        .Depth (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (in_accept && (dec.ram_rd || dec.ram_wr)),
        .i_we    (dec.ram_wr),
        .i_addr  (dec.ram_addr),
        .i_wdata (i_in_data.write_data),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_scroll  = r_scroll;
        n_pal     = r_pal;
        n_sub_rst = r_sub_rst;
        if (dec.wr_scroll_lo) begin
            n_scroll = {r_scroll[15:8], i_in_data.write_data};
        end
        if (dec.wr_scroll_hi) begin
            n_scroll = {i_in_data.write_data, r_scroll[7:0]};
        end
        if (dec.wr_palette) begin
            n_pal = i_in_data.write_data;
        end
        if (dec.wr_sub_reset) begin
            n_sub_rst = i_in_data.write_data[4];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank       <= '0;
            r_latch      <= '0;
            r_scroll     <= '0;
            r_pal        <= '0;
            r_sub_rst    <= 1'b0;
            r_chip_addr0 <= '0;
            r_chip_addr1 <= '0;
            r_last_coin  <= 1'b0;
            r_dip_a      <= '0;
            r_dip_b      <= '0;
        end else begin
            if (in_accept) begin
                r_scroll  <= n_scroll;
                r_pal     <= n_pal;
                r_sub_rst <= n_sub_rst;
                if (dec.wr_bank) begin
                    r_bank <= i_in_data.write_data;
                end
                if (dec.wr_latch) begin
                    r_latch <= i_in_data.write_data;
                end
                if (dec.wr_chip_addr && !dec.chip) begin
                    r_chip_addr0 <= i_in_data.write_data[3:0];
                end
                if (dec.wr_chip_addr && dec.chip) begin
                    r_chip_addr1 <= i_in_data.write_data[3:0];
                end
                if (dec.coin_upd) begin
                    r_last_coin <= i_in_data.buttons[0];
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DIP_A: r_dip_a <= i_cfg_wdata;
                    CFG_DIP_B: r_dip_b <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_use_ram         <= dec.ram_rd;
            r_s1_res.read_data   <= dec.read_data;
            r_s1_res.rom_region  <= dec.rom_region;
            r_s1_res.rom_offset  <= dec.rom_offset;
            r_s1_res.scroll_out  <= n_scroll;
            r_s1_res.palette_out <= n_pal;
            r_s1_res.cpu_b_reset <= n_sub_rst;
            r_s1_res.snd_write   <= dec.snd_write;
            r_s1_res.snd_index   <= dec.snd_index;
            r_s1_res.snd_value   <= dec.snd_value;
        end
        if (s1_adv) begin
            r_out <= s1_word;
        end
    end

    // merge RAM data, which holds while the stage waits
    always_comb begin
        s1_word = r_s1_res;
        if (r_s1_use_ram) begin
            s1_word.read_data = ram_rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
